// File: rtl/core/hash_partition_slot_allocator_macros.svh
// assertion macros for the hash partition slot allocator
`ifndef HASH_PARTITION_SLOT_ALLOCATOR_MACROS_SVH
`define HASH_PARTITION_SLOT_ALLOCATOR_MACROS_SVH

`ifndef SYNTH

`define HPSA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hpsa assertion failed");

`define HPSA_ASSERT_NEXT(label, ante, cons) \
    `HPSA_ASSERT(label, (ante) |=> (cons))

`else

`define HPSA_ASSERT(label, prop)

`define HPSA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/hpsa_pkg.sv
// shared types and constants of the hash partition slot allocator
package hpsa_pkg;

    localparam int KEY_W  = 64;
    localparam int HALF_W = 32;
    localparam int CAP_W  = 24;
    localparam int HB_W   = 4;
    localparam int PART_W = 10;

    localparam logic [HALF_W-1:0] HASH_MULT     = 32'h5bd1e995;
    localparam logic [HB_W-1:0]   PART_BITS_RST = 4'd4;
    localparam logic [CAP_W-1:0]  CAPACITY_RST  = 24'd1572864;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    typedef enum logic {
        REG_PART_BITS = 1'b0,
        REG_CAPACITY  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] payload;
    } t_tuple;

    typedef struct packed {
        logic [PART_W-1:0] partition;
        logic [CAP_W-1:0]  slot;
        t_tuple            tuple;
        logic              overflow;
    } t_result;

    typedef struct packed {
        logic clearing;
        logic stage_valid;
    } t_cnt_status;

endpackage

// File: rtl/core/hpsa_hash.sv
// two-stage multiplicative hash: split 64x32 multiply, then top-bit partition select
module hpsa_hash #(
    parameter int MAX_PARTITION_BITS = 10,
    parameter int EB_W = $clog2(MAX_PARTITION_BITS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  hpsa_pkg::t_tuple              i_tuple,
    input  logic [EB_W-1:0]               i_eff_bits,
    output logic                          o_valid,
    output logic [MAX_PARTITION_BITS-1:0] o_idx,
    output hpsa_pkg::t_tuple              o_tuple,
    output logic [1:0]                    o_inflight
);

    logic                            r_va;
    logic [2*hpsa_pkg::HALF_W-1:0]   r_prod_lo;
    logic [hpsa_pkg::HALF_W-1:0]     r_prod_hi;
    hpsa_pkg::t_tuple                r_tuple_a;

    logic                            r_vb;
    logic [MAX_PARTITION_BITS-1:0]   r_idx;
    hpsa_pkg::t_tuple                r_tuple_b;

    logic [2*hpsa_pkg::HALF_W-1:0]   n_prod_lo;
    logic [hpsa_pkg::HALF_W-1:0]     n_prod_hi;
    logic [hpsa_pkg::HALF_W-1:0]     htop;
    logic [5:0]                      shamt;
    logic [hpsa_pkg::HALF_W-1:0]     shifted;

    // only the low 32 bits of the upper product reach bits 63:32 of the hash
    assign n_prod_lo = {{hpsa_pkg::HALF_W{1'b0}}, i_tuple.key[hpsa_pkg::HALF_W-1:0]}
                     * {{hpsa_pkg::HALF_W{1'b0}}, hpsa_pkg::HASH_MULT};
    assign n_prod_hi = i_tuple.key[hpsa_pkg::KEY_W-1:hpsa_pkg::HALF_W] * hpsa_pkg::HASH_MULT;

    assign htop    = r_prod_lo[2*hpsa_pkg::HALF_W-1:hpsa_pkg::HALF_W] + r_prod_hi;
    assign shamt   = 6'd32 - 6'(i_eff_bits);
    assign shifted = htop >> shamt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_lo <= n_prod_lo;
        r_prod_hi <= n_prod_hi;
        r_tuple_a <= i_tuple;
        r_idx     <= shifted[MAX_PARTITION_BITS-1:0];
        r_tuple_b <= r_tuple_a;
    end

    assign o_valid    = r_vb;
    assign o_idx      = r_idx;
    assign o_tuple    = r_tuple_b;
    assign o_inflight = {r_va & r_vb, r_va ^ r_vb};

endmodule

// File: rtl/core/hpsa_count_mem.sv
// fill counter memory: read, compare against capacity, write back with forwarding
module hpsa_count_mem #(
    parameter int MAX_PARTITION_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [MAX_PARTITION_BITS-1:0] i_idx,
    input  hpsa_pkg::t_tuple              i_tuple,
    input  logic [hpsa_pkg::CAP_W-1:0]    i_capacity,
    output hpsa_pkg::t_result             o_result,
    output hpsa_pkg::t_cnt_status         o_status
);

    localparam int NUM_PARTS = 1 << MAX_PARTITION_BITS;

    logic [hpsa_pkg::CAP_W-1:0]    r_mem [NUM_PARTS];
    logic [hpsa_pkg::CAP_W-1:0]    r_rdata;

    logic                          r_vc;
    logic [MAX_PARTITION_BITS-1:0] r_idx_c;
    hpsa_pkg::t_tuple              r_tuple_c;

    logic                          r_fwd_valid;
    logic [MAX_PARTITION_BITS-1:0] r_fwd_addr;
    logic [hpsa_pkg::CAP_W-1:0]    r_fwd_data;

    logic                          r_clr_active;
    logic [MAX_PARTITION_BITS-1:0] r_clr_addr;

    logic [hpsa_pkg::CAP_W-1:0]    cnt;
    logic [hpsa_pkg::CAP_W-1:0]    n_count;
    logic                          full;
    logic                          we;
    logic [MAX_PARTITION_BITS-1:0] waddr;
    logic [hpsa_pkg::CAP_W-1:0]    wdata;
    logic [31:0]                   idx_ext;

    // the previous word's write lands on the same edge as this word's read
    assign cnt     = (r_fwd_valid && (r_fwd_addr == r_idx_c)) ? r_fwd_data : r_rdata;
    assign full    = cnt >= i_capacity;
    assign n_count = cnt + 1'b1;

    assign we    = r_clr_active || (r_vc && !full);
    assign waddr = r_clr_active ? r_clr_addr : r_idx_c;
    assign wdata = r_clr_active ? '0 : n_count;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[i_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc         <= 1'b0;
            r_fwd_valid  <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            r_vc        <= i_valid;
            r_fwd_valid <= r_vc;
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_c    <= i_idx;
        r_tuple_c  <= i_tuple;
        r_fwd_addr <= r_idx_c;
        r_fwd_data <= full ? cnt : n_count;
    end

    assign idx_ext = 32'(r_idx_c);

    always_comb begin
        o_result.partition = idx_ext[hpsa_pkg::PART_W-1:0];
        o_result.slot      = full ? '0 : cnt;
        o_result.tuple     = r_tuple_c;
        o_result.overflow  = full;
    end

    assign o_status.clearing    = r_clr_active;
    assign o_status.stage_valid = r_vc;

endmodule

// File: rtl/core/hpsa_out_fifo.sv
// result queue that decouples the pipeline from output backpressure
module hpsa_out_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  hpsa_pkg::t_result                   i_data,
    input  logic                                i_pop,
    output logic                                o_valid,
    output hpsa_pkg::t_result                   o_data,
    output logic [hpsa_pkg::FIFO_CNT_W-1:0]     o_count
);

    hpsa_pkg::t_result                   r_mem [hpsa_pkg::FIFO_DEPTH];
    logic [hpsa_pkg::FIFO_PTR_W-1:0]     r_wr_ptr;
    logic [hpsa_pkg::FIFO_PTR_W-1:0]     r_rd_ptr;
    logic [hpsa_pkg::FIFO_CNT_W-1:0]     r_count;
    logic [hpsa_pkg::FIFO_CNT_W-1:0]     n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: rtl/core/hash_partition_slot_allocator.sv
// pipeline: hash stages, then the count stage, then the output queue, which absorbs output stalls
// throughput: one word per cycle while tready is high, set by the fill-counter memory port, which
// reads one word's counter while writing back the previous one (forwarded on an address match)
// reset: synchronous active low; afterwards a clearing pass zeros all 2**MAX_PARTITION_BITS
// counters (1024 by default), no input word is taken meanwhile, configuration writes are
// taken at any time
`include "hash_partition_slot_allocator_macros.svh"

module hash_partition_slot_allocator #(
    parameter int MAX_PARTITION_BITS = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tdata: key [63:0], payload [127:64]
    input  logic [127:0] i_s_axis_tdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: partition [9:0], slot [33:10], key_out [97:34], payload_out [161:98], zero
    output logic [167:0] o_m_axis_tdata,
    // tuser: overflow [0]
    output logic         o_m_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int EB_W = $clog2(MAX_PARTITION_BITS + 1);

    logic [hpsa_pkg::HB_W-1:0]          r_part_bits;
    logic [hpsa_pkg::CAP_W-1:0]         r_capacity;
    logic [EB_W-1:0]                    eff_bits;
    logic                               cfg_wr;
    hpsa_pkg::t_reg_idx                 cfg_idx;

    logic                               s_in_accept;
    hpsa_pkg::t_tuple                   in_tuple;

    logic                               hash_valid;
    logic [MAX_PARTITION_BITS-1:0]      hash_idx;
    hpsa_pkg::t_tuple                   hash_tuple;
    logic [1:0]                         hash_inflight;

    hpsa_pkg::t_result                  cnt_result;
    hpsa_pkg::t_cnt_status              cnt_status;

    logic                               fifo_valid;
    hpsa_pkg::t_result                  fifo_data;
    logic [hpsa_pkg::FIFO_CNT_W-1:0]    fifo_count;
    logic                               out_pop;
    logic [hpsa_pkg::FIFO_CNT_W-1:0]    credit_use;
    logic [hpsa_pkg::FIFO_CNT_W-1:0]    inflight;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = hpsa_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_bits <= hpsa_pkg::PART_BITS_RST;
            r_capacity  <= hpsa_pkg::CAPACITY_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                hpsa_pkg::REG_PART_BITS: begin
                    r_part_bits <= pwdata[hpsa_pkg::HB_W-1:0];
                end
                hpsa_pkg::REG_CAPACITY: begin
                    r_capacity <= pwdata[hpsa_pkg::CAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            hpsa_pkg::REG_PART_BITS: prdata = 32'(r_part_bits);
            hpsa_pkg::REG_CAPACITY:  prdata = 32'(r_capacity);
            default:                 prdata = '0;
        endcase
    end

    // saturate the partition bit count into 1..MAX_PARTITION_BITS
    always_comb begin
        if (r_part_bits == '0) begin
            eff_bits = EB_W'(1);
        end else if (32'(r_part_bits) > MAX_PARTITION_BITS) begin
            eff_bits = EB_W'(MAX_PARTITION_BITS);
        end else begin
            eff_bits = EB_W'(r_part_bits);
        end
    end

    // admit a word only if the queue can hold it together with all words in flight
    assign inflight   = hpsa_pkg::FIFO_CNT_W'(hash_inflight)
                      + hpsa_pkg::FIFO_CNT_W'(cnt_status.stage_valid);
    assign credit_use = fifo_count + inflight;

    assign o_s_axis_tready = !cnt_status.clearing
                           && (credit_use < hpsa_pkg::FIFO_CNT_W'(hpsa_pkg::FIFO_DEPTH));
    assign s_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    assign in_tuple.key     = i_s_axis_tdata[63:0];
    assign in_tuple.payload = i_s_axis_tdata[127:64];

    hpsa_hash #(
        .MAX_PARTITION_BITS (MAX_PARTITION_BITS),
        .EB_W               (EB_W)
    ) u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_in_accept),
        .i_tuple    (in_tuple),
        .i_eff_bits (eff_bits),
        .o_valid    (hash_valid),
        .o_idx      (hash_idx),
        .o_tuple    (hash_tuple),
        .o_inflight (hash_inflight)
    );

    hpsa_count_mem #(
        .MAX_PARTITION_BITS (MAX_PARTITION_BITS)
    ) u_count_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (hash_valid),
        .i_idx      (hash_idx),
        .i_tuple    (hash_tuple),
        .i_capacity (r_capacity),
        .o_result   (cnt_result),
        .o_status   (cnt_status)
    );

    assign out_pop = fifo_valid && i_m_axis_tready;

    hpsa_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cnt_status.stage_valid),
        .i_data  (cnt_result),
        .i_pop   (out_pop),
        .o_valid (fifo_valid),
        .o_data  (fifo_data),
        .o_count (fifo_count)
    );

    assign o_m_axis_tvalid = fifo_valid;
    assign o_m_axis_tuser  = fifo_data.overflow;
    assign o_m_axis_tdata  = {6'b0,
                              fifo_data.tuple.payload,
                              fifo_data.tuple.key,
                              fifo_data.slot,
                              fifo_data.partition};

    `HPSA_ASSERT(a_credit_bound, (32'(fifo_count) + 32'(inflight)) <= hpsa_pkg::FIFO_DEPTH)
    `HPSA_ASSERT(a_overflow_slot_zero, (o_m_axis_tvalid && o_m_axis_tuser) |-> (fifo_data.slot == '0))
    `HPSA_ASSERT(a_pipe_latency, s_in_accept |-> ##3 cnt_status.stage_valid)
    `HPSA_ASSERT_NEXT(a_clear_empty, cnt_status.clearing, fifo_count == '0)

endmodule

// File: bench/tb_hash_partition_slot_allocator.sv
// testbench of the hash partition slot allocator: directed tuple table, then random tuples
module tb_hash_partition_slot_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W  = hpsa_pkg::KEY_W;
    localparam int CAP_W  = hpsa_pkg::CAP_W;
    localparam int PART_W = hpsa_pkg::PART_W;
    localparam int HB_W   = hpsa_pkg::HB_W;

    typedef hpsa_pkg::t_reg_idx t_reg_idx;
    typedef hpsa_pkg::t_result  t_result;

    localparam t_reg_idx SEL_BITS = hpsa_pkg::REG_PART_BITS;
    localparam t_reg_idx SEL_CAP  = hpsa_pkg::REG_CAPACITY;

    localparam int MAX_PB       = 10;
    localparam int N_PARTS      = 1 << MAX_PB;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int N_DIR        = 25;
    localparam int N_PHASES     = 5;

    localparam logic [KEY_W-1:0] ONES = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] MSB  = {1'b1, {(KEY_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ROW_TUPLE,
        ROW_TYPED,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_reg_idx          reg_sel;
        logic [CAP_W-1:0]  value;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  payload;
        logic [PART_W-1:0] part;
        logic [CAP_W-1:0]  slot;
        logic              ovf;
    } t_dir_row;

    typedef struct packed {
        logic [7:0]       tx_idle_pct;
        logic [7:0]       rx_stall_pct;
        logic [HB_W-1:0]  part_bits;
        logic [CAP_W-1:0] capacity;
        logic [15:0]      n_tuples;
        logic             hold;
    } t_phase;

    // typed rows: key 0 always lands in partition 0, all-ones key in 15 at 4 hash bits
    localparam t_dir_row DIRECTED [N_DIR] = '{
        '{ROW_TYPED, SEL_BITS, 24'd0, 64'd0, 64'd0, 10'd0, 24'd0, 1'b0},
        '{ROW_TYPED, SEL_BITS, 24'd0, 64'd0, ONES, 10'd0, 24'd1, 1'b0},
        '{ROW_TYPED, SEL_BITS, 24'd0, ONES, 64'h0123_4567_89ab_cdef, 10'd15, 24'd0, 1'b0},
        '{ROW_CFG, SEL_CAP, 24'd2, 64'd0, 64'd0, 10'd0, 24'd0, 1'b0},
        // partition full
        '{ROW_TYPED, SEL_BITS, 24'd0, 64'd0, 64'hfeed_face_cafe_f00d, 10'd0, 24'd0, 1'b1},
        '{ROW_TYPED, SEL_BITS, 24'd0, ONES, 64'h5555_5555_5555_5555, 10'd15, 24'd1, 1'b0},
        '{ROW_TYPED, SEL_BITS, 24'd0, ONES, 64'haaaa_aaaa_aaaa_aaaa, 10'd15, 24'd0, 1'b1},
        // capacity lowered below a counter
        '{ROW_CFG, SEL_CAP, 24'd1, 64'd0, 64'd0, 10'd0, 24'd0, 1'b0},
        '{ROW_TYPED, SEL_BITS, 24'd0, 64'd0, 64'h0f0f_0f0f_0f0f_0f0f, 10'd0, 24'd0, 1'b1},
        // zero capacity
        '{ROW_CFG, SEL_CAP, 24'd0, 64'd0, 64'd0, 10'd0, 24'd0, 1'b0},
        '{ROW_TYPED, SEL_BITS, 24'd0, ONES, ONES, 10'd15, 24'd0, 1'b1},
        '{ROW_TUPLE, SEL_BITS, 24'd0, 64'd1, 64'hf0f0_f0f0_f0f0_f0f0, 10'd0, 24'd0, 1'b0},
        '{ROW_TUPLE, SEL_BITS, 24'd0, MSB, 64'h1357_9bdf_2468_ace0, 10'd0, 24'd0, 1'b0},
        // hash bits 0 acts as 1
        '{ROW_CFG, SEL_BITS, 24'd0, 64'd0, 64'd0, 10'd0, 24'd0, 1'b0},
        '{ROW_CFG, SEL_CAP, 24'hff_ffff, 64'd0, 64'd0, 10'd0, 24'd0, 1'b0},
        '{ROW_TYPED, SEL_BITS, 24'd0, 64'd0, 64'h8421_8421_8421_8421, 10'd0, 24'd2, 1'b0},
        '{ROW_TUPLE, SEL_BITS, 24'd0, ONES, 64'h7e7e_7e7e_7e7e_7e7e, 10'd0, 24'd0, 1'b0},
        // hash bits above the maximum act as the maximum
        '{ROW_CFG, SEL_BITS, 24'd15, 64'd0, 64'd0, 10'd0, 24'd0, 1'b0},
        '{ROW_TUPLE, SEL_BITS, 24'd0, ONES, 64'd0, 10'd0, 24'd0, 1'b0},
        '{ROW_TUPLE, SEL_BITS, 24'd0, 64'h0000_0000_ffff_ffff, ONES, 10'd0, 24'd0, 1'b0},
        '{ROW_CFG, SEL_BITS, 24'd10, 64'd0, 64'd0, 10'd0, 24'd0, 1'b0},
        '{ROW_TUPLE, SEL_BITS, 24'd0, 64'hdead_beef_0123_4567, MSB, 10'd0, 24'd0, 1'b0},
        '{ROW_TUPLE, SEL_BITS, 24'd0, ONES, 64'd1, 10'd0, 24'd0, 1'b0},
        '{ROW_CFG, SEL_BITS, 24'd1, 64'd0, 64'd0, 10'd0, 24'd0, 1'b0},
        '{ROW_TUPLE, SEL_BITS, 24'd0, MSB, 64'h3c3c_3c3c_3c3c_3c3c, 10'd0, 24'd0, 1'b0}
    };

    localparam t_phase PHASES [N_PHASES] = '{
        '{8'd0, 8'd0, 4'd1, 24'd150, 16'd300, 1'b0},
        '{8'd70, 8'd0, 4'd10, 24'hff_ffff, 16'd250, 1'b0},
        '{8'd0, 8'd70, 4'd3, 24'd40, 16'd250, 1'b0},
        '{8'd23, 8'd23, 4'd15, 24'd1, 16'd250, 1'b0},
        '{8'd0, 8'd0, 4'd6, 24'd1000, 16'd200, 1'b1}
    };

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic [127:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] m_tdata;
    logic         m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // shadow of the block state
    logic [CAP_W-1:0] fill_cnt [N_PARTS];
    logic [HB_W-1:0]  cur_part_bits;
    logic [CAP_W-1:0] cur_capacity;
    t_result          pending_results [$];

    int   errors = 0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    hash_partition_slot_allocator #(
        .MAX_PARTITION_BITS(MAX_PB)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #10 clk = ~clk;

    // slot allocation for one tuple; advances the shadow fill counter unless the partition is full
    function automatic t_result allocate_slot(input logic [KEY_W-1:0] key,
                                              input logic [KEY_W-1:0] payload);
        logic [KEY_W-1:0]  h;
        int                bits;
        logic [PART_W-1:0] p;
        t_result           r;
        h = key * {32'd0, hpsa_pkg::HASH_MULT};
        if (cur_part_bits == 0)
            bits = 1;
        else if (int'(cur_part_bits) > MAX_PB)
            bits = MAX_PB;
        else
            bits = int'(cur_part_bits);
        p = PART_W'(h >> (KEY_W - bits));
        r.partition     = p;
        r.tuple.key     = key;
        r.tuple.payload = payload;
        if (fill_cnt[p] >= cur_capacity) begin
            r.slot     = '0;
            r.overflow = 1'b1;
        end else begin
            r.slot      = fill_cnt[p];
            r.overflow  = 1'b0;
            fill_cnt[p] = fill_cnt[p] + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] rand_word();
        logic [KEY_W-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(19))
            0: w = '0;
            1: w = ONES;
            2: w = 64'd1 << $urandom_range(63);
            3: w = ~(64'd1 << $urandom_range(63));
            default: ;
        endcase
        return w;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [CAP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // return to idle before the next transfer
        @(posedge clk);
        if (idx == SEL_BITS)
            cur_part_bits = value[HB_W-1:0];
        else
            cur_capacity = value;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_tuple(input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] payload,
                              input logic typed, input t_result typed_res);
        t_result r;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {payload, key};
        do @(posedge clk); while (!s_tready);
        r = allocate_slot(key, payload);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] exp_v,
                               input logic [KEY_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %h, actual %h", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    initial begin
        t_result          typed_res;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] pl;
        for (int i = 0; i < N_PARTS; i++)
            fill_cnt[i] = '0;
        cur_part_bits = hpsa_pkg::PART_BITS_RST;
        cur_capacity  = hpsa_pkg::CAPACITY_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(DIRECTED[i].reg_sel, DIRECTED[i].value);
            end else begin
                typed_res.partition     = DIRECTED[i].part;
                typed_res.slot          = DIRECTED[i].slot;
                typed_res.tuple.key     = DIRECTED[i].key;
                typed_res.tuple.payload = DIRECTED[i].payload;
                typed_res.overflow      = DIRECTED[i].ovf;
                send_tuple(DIRECTED[i].key, DIRECTED[i].payload,
                           DIRECTED[i].kind == ROW_TYPED, typed_res);
            end
        end

        typed_res = '0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            write_reg(SEL_BITS, CAP_W'(PHASES[ph].part_bits));
            write_reg(SEL_CAP, PHASES[ph].capacity);
            tx_idle_pct  = int'(PHASES[ph].tx_idle_pct);
            rx_stall_pct = int'(PHASES[ph].rx_stall_pct);
            if (PHASES[ph].hold)
                hold_req <= 1'b1;
            for (int n = 0; n < int'(PHASES[ph].n_tuples); n++) begin
                k  = rand_word();
                pl = rand_word();
                send_tuple(k, pl, 1'b0, typed_res);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // receiver; one long hold-off when the pressure phase asks for it
    always @(posedge clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk) begin : check_word
        t_result exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected word: expected none, actual %h user %b",
                         $realtime, m_tdata, m_tuser);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("partition", KEY_W'(exp_r.partition), KEY_W'(m_tdata[9:0]));
                check_field("slot", KEY_W'(exp_r.slot), KEY_W'(m_tdata[33:10]));
                check_field("key", exp_r.tuple.key, m_tdata[97:34]);
                check_field("payload", exp_r.tuple.payload, m_tdata[161:98]);
                check_field("overflow", KEY_W'(exp_r.overflow), KEY_W'(m_tuser));
            end
        end
    end

    // watchdog: cycles in which no word moves on either side
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog: no word moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
